// ===== sv/pltc_pkg.sv =====
package pltc_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int TEMP_W    = 31;
  localparam int CNT_REG_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int POINT_W   = 2 * DATA_W;

  localparam int MAG_W  = DATA_W + 1;
  localparam int QUOT_W = 42;
  localparam int SUM_W  = 44;

  localparam logic [CFG_IDX_W-1:0] REG_CONV_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEN   = 2'd3;

  localparam logic OP_WRITE_POINT = 1'b0;
  localparam logic OP_CONVERT     = 1'b1;

  localparam logic MODE_TABLE  = 1'b0;
  localparam logic MODE_SCALAR = 1'b1;

  localparam logic signed [SUM_W-1:0] KELVIN_OFFSET = 44'sd273150;
  localparam logic signed [SUM_W-1:0] TEMP_MAX      = 44'sd2147483647;
  localparam logic [QUOT_W-2:0]       QUOT_LIMIT    = 41'h100_0000_0000;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
    logic             prod_neg;
    logic [MAG_W-1:0] den_mag;
    logic             den_neg;
  } arith_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } arith_rsp_t;

  function automatic logic [MAG_W-1:0] mag33(input logic [MAG_W-1:0] v);
    logic [MAG_W-1:0] neg;
    neg = ~v + 1'b1;
    return v[MAG_W-1] ? neg : v;
  endfunction

endpackage

// ===== sv/pltc_in_if.sv =====
interface pltc_in_if;
  import pltc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         point_index;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] sample;

  modport source (
    output valid, opcode, point_index, point_x, point_y, sample,
    input  ready
  );

  modport sink (
    input  valid, opcode, point_index, point_x, point_y, sample,
    output ready
  );
endinterface

// ===== sv/pltc_out_if.sv =====
interface pltc_out_if;
  import pltc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_mc;
  logic              status;

  modport source (
    output valid, temperature_mc, status,
    input  ready
  );

  modport sink (
    input  valid, temperature_mc, status,
    output ready
  );
endinterface

// ===== sv/piecewise_linear_temp_convert_top.sv =====
// Piecewise-linear temperature converter.
// Input channel in_ch carries two kinds of beat. A point write (opcode 0)
// stores (point_x, point_y) into table slot point_index and gives no
// result. A convert (opcode 1) turns sample into millicelsius and gives
// one beat on out_ch: temperature_mc and status (1 on a zero divisor).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) for
// mode, point count and the scalar numerator and denominator.
// A convert in scalar mode runs a byte-serial multiply and a bit-serial
// divide. In table mode a binary segment search comes first, each probe
// on the single read port of the table RAM, then two table reads for the
// segment ends.
// One item is in work at a time; in_ch.ready is high only between items.
// The finished result sits in an output register, so the next item is
// accepted while a result waits. If out_ch stalls, a second result holds
// in the block until the first is taken.
// Reset restores the configuration registers; the point table holds
// nothing meaningful until written.
module piecewise_linear_temp_convert_top #(
  parameter int MAX_POINTS = pltc_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pltc_in_if.sink                           in_ch,
  pltc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pltc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pltc_pkg::DATA_W-1:0]       cfg_wdata
);
  import pltc_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = ($clog2(MAX_POINTS + 1) < CNT_REG_W + 1) ?
                        CNT_REG_W + 1 : $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAIT,
    S_RDH,
    S_RDL,
    S_SEG,
    S_ARITH,
    S_DONE
  } state_t;

  logic                     conv_mode_r;
  logic [CNT_REG_W-1:0]     point_count_r;
  logic signed [DATA_W-1:0] scale_num_r;
  logic signed [DATA_W-1:0] scale_den_r;

  state_t                   state_r;
  logic [IW-1:0]            l_r;
  logic [IW-1:0]            h_r;
  logic signed [DATA_W-1:0] sample_r;
  logic signed [DATA_W-1:0] xh_r;
  logic signed [DATA_W-1:0] yh_r;
  logic signed [DATA_W-1:0] addend_r;
  logic [TEMP_W-1:0]        res_temp_r;
  logic                     res_status_r;
  arith_req_t               arith_req_r;
  arith_rsp_t               arith_rsp;

  logic                     out_valid_r;
  logic [TEMP_W-1:0]        out_temp_r;
  logic                     out_status_r;

  logic                     in_accept;
  logic                     ram_we;
  logic [IW-1:0]            ram_wr_addr;
  logic [POINT_W-1:0]       ram_wr_data;
  logic [IW-1:0]            ram_rd_addr;
  logic [POINT_W-1:0]       ram_rd_data;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;

  logic [CNTW-1:0]          cnt_ext;
  logic [CNTW-1:0]          cnt_eff;
  logic [IW-1:0]            h_init;
  logic [IW:0]              mid_sum;
  logic [IW-1:0]            mid;
  logic                     search_go;
  logic                     arith_go;

  logic signed [MAG_W-1:0]  seg_den;
  logic signed [MAG_W-1:0]  seg_dy;
  logic signed [MAG_W-1:0]  seg_dxs;
  logic signed [MAG_W-1:0]  smp_ext;
  logic signed [MAG_W-1:0]  num_ext;
  logic signed [MAG_W-1:0]  den_ext;

  logic signed [SUM_W-1:0]  sum_t;
  logic [TEMP_W-1:0]        temp_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_mode_r   <= MODE_TABLE;
      point_count_r <= CNT_REG_W'(2);
      scale_num_r   <= 32'sd1;
      scale_den_r   <= 32'sd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONV_MODE:   conv_mode_r   <= cfg_wdata[0];
        REG_POINT_COUNT: point_count_r <= cfg_wdata[CNT_REG_W-1:0];
        REG_SCALE_NUM:   scale_num_r   <= $signed(cfg_wdata);
        REG_SCALE_DEN:   scale_den_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign ram_we      = in_accept && (in_ch.opcode == OP_WRITE_POINT) &&
                       (CNTW'(in_ch.point_index) < CNTW'(MAX_POINTS));
  assign ram_wr_addr = IW'(in_ch.point_index);
  assign ram_wr_data = {in_ch.point_x, in_ch.point_y};
  assign rd_x        = $signed(ram_rd_data[POINT_W-1:DATA_W]);
  assign rd_y        = $signed(ram_rd_data[DATA_W-1:0]);

  pltc_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pltc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req_r),
    .rsp   (arith_rsp)
  );

  assign cnt_ext = CNTW'(point_count_r);
  assign cnt_eff = (cnt_ext < CNTW'(2)) ? CNTW'(2) :
                   (cnt_ext > CNTW'(MAX_POINTS)) ? CNTW'(MAX_POINTS) : cnt_ext;
  assign h_init  = IW'(cnt_eff - CNTW'(1));

  assign mid_sum   = {1'b0, l_r} + {1'b0, h_r};
  assign mid       = mid_sum[IW:1];
  assign search_go = {1'b0, h_r} > ({1'b0, l_r} + (IW + 1)'(1));

  always_comb begin
    if (state_r == S_SEARCH) begin
      ram_rd_addr = mid;
    end else if (state_r == S_RDH) begin
      ram_rd_addr = h_r;
    end else begin
      ram_rd_addr = h_r - 1'b1;
    end
  end

  assign seg_den = $signed({xh_r[DATA_W-1], xh_r}) - $signed({rd_x[DATA_W-1], rd_x});
  assign seg_dy  = $signed({yh_r[DATA_W-1], yh_r}) - $signed({rd_y[DATA_W-1], rd_y});
  assign seg_dxs = $signed({sample_r[DATA_W-1], sample_r}) -
                   $signed({rd_x[DATA_W-1], rd_x});

  assign smp_ext = $signed({in_ch.sample[DATA_W-1], in_ch.sample});
  assign num_ext = $signed({scale_num_r[DATA_W-1], scale_num_r});
  assign den_ext = $signed({scale_den_r[DATA_W-1], scale_den_r});

  assign arith_go = (in_accept && (in_ch.opcode == OP_CONVERT) &&
                     (conv_mode_r == MODE_SCALAR) && (scale_den_r != '0)) ||
                    ((state_r == S_SEG) && (seg_den != '0));

  assign sum_t = $signed({{(SUM_W - QUOT_W){arith_rsp.quot[QUOT_W-1]}}, arith_rsp.quot}) +
                 $signed({{(SUM_W - DATA_W){addend_r[DATA_W-1]}}, addend_r}) -
                 KELVIN_OFFSET;

  always_comb begin
    priority if (sum_t < 0) begin
      temp_nxt = '0;
    end else if (sum_t > TEMP_MAX) begin
      temp_nxt = TEMP_MAX[TEMP_W-1:0];
    end else begin
      temp_nxt = sum_t[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      arith_req_r.start <= 1'b0;
    end else begin
      arith_req_r.start <= arith_go;
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && (in_ch.opcode == OP_CONVERT)) begin
            sample_r <= in_ch.sample;
            if (conv_mode_r == MODE_SCALAR) begin
              if (scale_den_r == '0) begin
                res_temp_r   <= '0;
                res_status_r <= 1'b1;
                state_r      <= S_DONE;
              end else begin
                arith_req_r.a_mag    <= mag33(smp_ext);
                arith_req_r.b_mag    <= mag33(num_ext);
                arith_req_r.prod_neg <= smp_ext[MAG_W-1] ^ num_ext[MAG_W-1];
                arith_req_r.den_mag  <= mag33(den_ext);
                arith_req_r.den_neg  <= den_ext[MAG_W-1];
                addend_r             <= '0;
                state_r              <= S_ARITH;
              end
            end else begin
              l_r     <= '0;
              h_r     <= h_init;
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          state_r <= search_go ? S_SWAIT : S_RDH;
        end
        S_SWAIT: begin
          if (rd_x < sample_r) begin
            l_r <= mid;
          end else begin
            h_r <= mid;
          end
          state_r <= S_SEARCH;
        end
        S_RDH: begin
          state_r <= S_RDL;
        end
        S_RDL: begin
          xh_r    <= rd_x;
          yh_r    <= rd_y;
          state_r <= S_SEG;
        end
        S_SEG: begin
          if (seg_den == '0) begin
            res_temp_r   <= '0;
            res_status_r <= 1'b1;
            state_r      <= S_DONE;
          end else begin
            arith_req_r.a_mag    <= mag33(seg_dy);
            arith_req_r.b_mag    <= mag33(seg_dxs);
            arith_req_r.prod_neg <= seg_dy[MAG_W-1] ^ seg_dxs[MAG_W-1];
            arith_req_r.den_mag  <= mag33(seg_den);
            arith_req_r.den_neg  <= seg_den[MAG_W-1];
            addend_r             <= rd_y;
            state_r              <= S_ARITH;
          end
        end
        S_ARITH: begin
          if (arith_rsp.done) begin
            res_temp_r   <= temp_nxt;
            res_status_r <= 1'b0;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_temp_r   <= res_temp_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.temperature_mc = out_temp_r;
  assign out_ch.status         = out_status_r;

endmodule

// ===== sv/pltc_ram.sv =====
module pltc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pltc_arith.sv =====
module pltc_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pltc_pkg::arith_req_t req,
  output pltc_pkg::arith_rsp_t rsp
);
  import pltc_pkg::*;

  localparam int DIGIT_W    = 8;
  localparam int MUL_B_W    = 40;
  localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
  localparam int PROD_W     = 2 * DATA_W + 1;
  localparam int DIVIDEND_W = 2 * DATA_W;
  localparam int STEP_W     = 7;
  localparam int DPROD_W    = MAG_W + DIGIT_W;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_SIGN,
    A_ABS,
    A_DIV,
    A_CLAMP
  } astate_t;

  astate_t                 state_r;
  logic [STEP_W-1:0]       step_r;
  logic [MAG_W-1:0]        a_r;
  logic [MUL_B_W-1:0]      b_r;
  logic [PROD_W-1:0]       acc_r;
  logic                    prod_neg_r;
  logic [MAG_W-1:0]        den_r;
  logic                    den_neg_r;
  logic [DIVIDEND_W-1:0]   quo_r;
  logic [MAG_W-1:0]        rem_r;
  logic                    qneg_r;
  arith_rsp_t              rsp_r;

  logic [DPROD_W-1:0]      digit_prod;
  logic [PROD_W-1:0]       acc_nxt;
  logic [MAG_W:0]          div_sh;
  logic [MAG_W:0]          div_diff;
  logic                    div_fits;
  logic [QUOT_W-2:0]       quot_mag;
  logic [QUOT_W-1:0]       quot_ext;
  logic signed [QUOT_W-1:0] quot_nxt;

  assign digit_prod = a_r * b_r[MUL_B_W-1 -: DIGIT_W];
  assign acc_nxt    = {acc_r[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(digit_prod);

  assign div_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
  assign div_diff = div_sh - {1'b0, den_r};
  assign div_fits = div_sh >= {1'b0, den_r};

  assign quot_mag = (quo_r > DIVIDEND_W'(QUOT_LIMIT)) ? QUOT_LIMIT : quo_r[QUOT_W-2:0];
  assign quot_ext = {1'b0, quot_mag};
  assign quot_nxt = qneg_r ? $signed(~quot_ext + 1'b1) : $signed(quot_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= A_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= (state_r == A_CLAMP);
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            a_r        <= req.a_mag;
            b_r        <= MUL_B_W'(req.b_mag);
            acc_r      <= '0;
            prod_neg_r <= req.prod_neg;
            den_r      <= req.den_mag;
            den_neg_r  <= req.den_neg;
            step_r     <= '0;
            state_r    <= A_MUL;
          end
        end
        A_MUL: begin
          acc_r  <= acc_nxt;
          b_r    <= {b_r[MUL_B_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MUL_STEPS - 1)) begin
            state_r <= A_SIGN;
          end
        end
        A_SIGN: begin
          quo_r   <= prod_neg_r ? (~acc_r[DIVIDEND_W-1:0] + 1'b1) : acc_r[DIVIDEND_W-1:0];
          state_r <= A_ABS;
        end
        A_ABS: begin
          quo_r   <= quo_r[DIVIDEND_W-1] ? (~quo_r + 1'b1) : quo_r;
          qneg_r  <= quo_r[DIVIDEND_W-1] ^ den_neg_r;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= A_DIV;
        end
        A_DIV: begin
          rem_r  <= div_fits ? div_diff[MAG_W-1:0] : div_sh[MAG_W-1:0];
          quo_r  <= {quo_r[DIVIDEND_W-2:0], div_fits};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
            state_r <= A_CLAMP;
          end
        end
        A_CLAMP: begin
          rsp_r.quot <= quot_nxt;
          state_r    <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule
